// ----- hdl/smrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package smrl_pkg;

  // serial shifter: marker bit at the top, no data bits loaded
  localparam logic [5:0] SHIFT_EMPTY = 6'h20;
  // write_value bit that clears the shifter
  localparam int unsigned CLEAR_BIT = 7;
  // mapper register reset values
  localparam logic [4:0] CTRL_RESET = 5'h08;
  localparam logic [4:0] CHR_RESET  = 5'h00;
  localparam logic [4:0] PRG_RESET  = 5'h0F;

  // what the back end does with one write
  typedef enum logic [1:0] {
    CMD_IGNORE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SHIFT  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  sel;
    logic        data_bit;
  } cmd_t;

  // command queue handshake toward the back end
  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } cmd_rd_t;

  // result item
  typedef struct packed {
    logic [4:0] control_value;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [4:0] prg_bank;
    logic       committed;
    logic       ignored;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/serial_mapper_register_loader.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake       payload
// in_       input      in_push/in_full  reg_select, write_value, cycle_number
// out_      output     out_pop/out_empty control_value, chr_bank_low, chr_bank_high,
//                                       prg_bank, committed, ignored
//
// one write per cycle sustained while in_full is low; a result shows on the out_ ports
// after its queued command is executed by the back and stored in the result queue
// the back applies one command per cycle while the result queue has room
// synchronous active-low reset restores the shifter marker, all-ones recorded cycle
// and the default mapper register values; both queues start empty
// two-entry queues on each side; in_full rises only when both fill behind a stalled pop
module serial_mapper_register_loader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_reg_select,
  input  wire logic [7:0]  in_write_value,
  input  wire logic [63:0] in_cycle_number,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [4:0]       out_control_value,
  output logic [4:0]       out_chr_bank_low,
  output logic [4:0]       out_chr_bank_high,
  output logic [4:0]       out_prg_bank,
  output logic             out_committed,
  output logic             out_ignored
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  smrl_pkg::cmd_t    q_cmd;
  smrl_pkg::cmd_rd_t q_rd;

  assign in_full = q_full;

  // classify writes
  smrl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_reg_select   (in_reg_select),
    .in_write_value  (in_write_value),
    .in_cycle_number (in_cycle_number),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // command queue between front and back
  smrl_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd       (q_rd)
  );

  // shifter, mapper registers and result queue
  smrl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_rd            (q_rd),
    .cmd_pop           (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_control_value (out_control_value),
    .out_chr_bank_low  (out_chr_bank_low),
    .out_chr_bank_high (out_chr_bank_high),
    .out_prg_bank      (out_prg_bank),
    .out_committed     (out_committed),
    .out_ignored       (out_ignored)
  );

endmodule
`default_nettype wire

// ----- hdl/smrl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module smrl_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic [1:0]       in_reg_select,
  input  wire logic [7:0]       in_write_value,
  input  wire logic [63:0]      in_cycle_number,
  input  wire logic             q_full,
  output logic                  q_push,
  output smrl_pkg::cmd_t        q_cmd
);

  logic [63:0] prev_cycle_r;
  logic [63:0] prev_cycle_nxt;
  logic [63:0] cycle_diff;
  logic        back_to_back;

  // consecutive-cycle test, modulo 2^64
  assign cycle_diff   = in_cycle_number - prev_cycle_r;
  assign back_to_back = (cycle_diff == 64'd1);
  assign q_push       = in_push && !q_full;

  // classify the write
  always_comb begin
    q_cmd.sel      = in_reg_select;
    q_cmd.data_bit = in_write_value[0];
    prev_cycle_nxt = prev_cycle_r;
    if (back_to_back) begin
      q_cmd.kind     = smrl_pkg::CMD_IGNORE;
      prev_cycle_nxt = in_cycle_number;
    end else if (in_write_value[smrl_pkg::CLEAR_BIT]) begin
      q_cmd.kind = smrl_pkg::CMD_CLEAR;
    end else begin
      q_cmd.kind     = smrl_pkg::CMD_SHIFT;
      prev_cycle_nxt = in_cycle_number;
    end
  end

  // recorded cycle of the last shift or ignored write; clear writes leave it unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cycle_r <= '1;
    end else if (q_push) begin
      prev_cycle_r <= prev_cycle_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/smrl_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module smrl_cmd_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire smrl_pkg::cmd_t   push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output smrl_pkg::cmd_rd_t     rd
);

  smrl_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign full     = (count_r == 2'd2);
  assign rd.empty = (count_r == 2'd0);
  assign rd.cmd   = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !rd.empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/smrl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module smrl_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smrl_pkg::cmd_rd_t cmd_rd,
  output logic                   cmd_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [4:0]             out_control_value,
  output logic [4:0]             out_chr_bank_low,
  output logic [4:0]             out_chr_bank_high,
  output logic [4:0]             out_prg_bank,
  output logic                   out_committed,
  output logic                   out_ignored
);

  logic [5:0]        shifter_r;
  logic [5:0]        shifter_nxt;
  logic [4:0]        regs_r   [4];
  logic [4:0]        regs_nxt [4];
  logic [5:0]        shifted;
  logic              committed;
  logic              ignored;
  smrl_pkg::result_t res;

  smrl_pkg::result_t res_mem_r [2];
  logic              res_wr_ptr_r;
  logic              res_rd_ptr_r;
  logic [1:0]        res_count_r;
  logic              res_full;
  logic              res_pop;

  assign res_full = (res_count_r == 2'd2);
  assign cmd_pop  = !cmd_rd.empty && !res_full;
  assign shifted  = {cmd_rd.cmd.data_bit, shifter_r[5:1]};

  // execute one command
  always_comb begin
    shifter_nxt = shifter_r;
    regs_nxt    = regs_r;
    committed   = 1'b0;
    ignored     = 1'b0;
    unique case (cmd_rd.cmd.kind)
      smrl_pkg::CMD_IGNORE: begin
        ignored = 1'b1;
      end
      smrl_pkg::CMD_CLEAR: begin
        shifter_nxt = smrl_pkg::SHIFT_EMPTY;
      end
      smrl_pkg::CMD_SHIFT: begin
        if (shifted[0]) begin
          regs_nxt[cmd_rd.cmd.sel] = shifted[5:1];
          shifter_nxt              = smrl_pkg::SHIFT_EMPTY;
          committed                = 1'b1;
        end else begin
          shifter_nxt = shifted;
        end
      end
      default: begin
        shifter_nxt = shifter_r;
      end
    endcase
    res.control_value = regs_nxt[0];
    res.chr_bank_low  = regs_nxt[1];
    res.chr_bank_high = regs_nxt[2];
    res.prg_bank      = regs_nxt[3];
    res.committed     = committed;
    res.ignored       = ignored;
  end

  // shifter and mapper registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shifter_r <= smrl_pkg::SHIFT_EMPTY;
      regs_r[0] <= smrl_pkg::CTRL_RESET;
      regs_r[1] <= smrl_pkg::CHR_RESET;
      regs_r[2] <= smrl_pkg::CHR_RESET;
      regs_r[3] <= smrl_pkg::PRG_RESET;
    end else if (cmd_pop) begin
      shifter_r <= shifter_nxt;
      regs_r    <= regs_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_mem_r[res_wr_ptr_r] <= res;
    end
  end

  // result queue pointers and fill count
  assign out_empty = (res_count_r == 2'd0);
  assign res_pop   = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_ptr_r <= 1'b0;
      res_rd_ptr_r <= 1'b0;
      res_count_r  <= 2'd0;
    end else begin
      if (cmd_pop) begin
        res_wr_ptr_r <= !res_wr_ptr_r;
      end
      if (res_pop) begin
        res_rd_ptr_r <= !res_rd_ptr_r;
      end
      if (cmd_pop && !res_pop) begin
        res_count_r <= res_count_r + 2'd1;
      end else if (res_pop && !cmd_pop) begin
        res_count_r <= res_count_r - 2'd1;
      end
    end
  end

  // oldest result on the ports
  assign out_control_value = res_mem_r[res_rd_ptr_r].control_value;
  assign out_chr_bank_low  = res_mem_r[res_rd_ptr_r].chr_bank_low;
  assign out_chr_bank_high = res_mem_r[res_rd_ptr_r].chr_bank_high;
  assign out_prg_bank      = res_mem_r[res_rd_ptr_r].prg_bank;
  assign out_committed     = res_mem_r[res_rd_ptr_r].committed;
  assign out_ignored       = res_mem_r[res_rd_ptr_r].ignored;

endmodule
`default_nettype wire
